FILE: hdl/tint_pkg.sv
`default_nettype none

package tint_pkg;

    // Table size and fixed field widths.
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int Q_W             = 32;
    localparam int IDX_W           = 6;
    localparam int COUNT_W         = 7;
    localparam int SEG_W           = 6;

    // Stream packing.
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 40;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Shared divider: full product over a segment width.
    localparam int DIVIDEND_W = 2 * Q_W;
    localparam int DIVISOR_W  = Q_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERP_MODE = 1'b0,
        REG_POINT_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic {
        MODE_LINEAR = 1'b0,
        MODE_STEP   = 1'b1
    } mode_t;

    typedef enum logic {
        STATUS_OK  = 1'b0,
        STATUS_FEW = 1'b1
    } status_t;

endpackage

`default_nettype wire

FILE: hdl/tint_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is shifted
// into the dividend register as the dividend bits leave it.
module tint_div
    import tint_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    logic [DIVIDEND_W-1:0] work_reg;
    logic [DIVIDEND_W-1:0] work_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIV_CNT_W-1:0]  count_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_sub;
    logic                  fits;

    // One trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        trial     = {rem_reg, work_reg[DIVIDEND_W-1]};
        trial_sub = trial - {1'b0, dsr_reg};
        fits      = (trial >= {1'b0, dsr_reg});
        rem_next  = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        work_next = {work_reg[DIVIDEND_W-2:0], fits};
    end

    // Step counter and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg  <= '0;
            rem_reg   <= '0;
            dsr_reg   <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            // Done pulses for one cycle after the last quotient bit.
            done_reg <= busy_reg && !start && (count_reg == DIV_CNT_W'(1));
            if (start)
            begin
                work_reg  <= dividend;
                rem_reg   <= '0;
                dsr_reg   <= divisor;
                count_reg <= DIV_CNT_W'(DIVIDEND_W);
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                work_reg  <= work_next;
                rem_reg   <= rem_next;
                count_reg <= count_reg - DIV_CNT_W'(1);
                if (count_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

`default_nettype wire

FILE: hdl/table_interpolator_top.sv
// Breakpoint writes are accepted back to back. A query holds s_tready low
// until its result is in the output register. With fewer than two points
// it gives a zero result with status FEW; a query at or beyond either table
// end is clamped to that end's y. Otherwise a downward scan reads one table
// entry per cycle to find the left breakpoint, where step mode ends; linear
// mode then reads the right breakpoint, gives y0 if its x does not exceed x0,
// and else uses the 64-step restoring divider.
// rst_n clears mode, point count and control at once; the table is not cleared.
`default_nettype none

module table_interpolator_top
    import tint_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [5:0] point_index, [37:6] point_x, [69:38] point_y, [101:70] query_x
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // [0] op
    input  wire logic                   s_tuser,
    // Result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [31:0] result_y, [37:32] segment_index
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // [0] status
    output logic                        m_tuser,
    // Configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD0,
        ST_LOADN,
        ST_SCAN,
        ST_LOAD1,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_FINISH
    } state_t;

    state_t                  state_reg;

    logic                    mode_reg;
    logic [COUNT_W-1:0]      count_reg;

    logic [COUNT_W-1:0]      n_reg;
    logic [COUNT_W-1:0]      scan_reg;
    logic signed [Q_W-1:0]   qx_reg;
    logic signed [Q_W-1:0]   x0_reg;
    logic signed [Q_W-1:0]   y0_reg;
    logic [Q_W-1:0]          dx_reg;
    logic [Q_W-1:0]          mag_reg;
    logic [Q_W-1:0]          den_reg;
    logic                    neg_reg;
    logic [DIVIDEND_W-1:0]   prod_reg;
    logic                    div_start_reg;
    logic [Q_W-1:0]          res_y_reg;
    logic [COUNT_W-1:0]      seg_reg;
    logic                    status_reg;
    logic                    m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;
    logic                    m_tuser_reg;

    logic [2*Q_W-1:0]        tbl_mem [TABLE_DEPTH];
    logic [2*Q_W-1:0]        rd_data_reg;
    logic [AW-1:0]           rd_addr;

    logic                    in_acc;
    logic [IDX_W-1:0]        in_idx;
    logic [Q_W-1:0]          in_px;
    logic [Q_W-1:0]          in_py;
    logic signed [Q_W-1:0]   in_qx;
    logic                    wr_en;
    logic [COUNT_W-1:0]      n_eff;
    logic [COUNT_W-1:0]      n_m1;
    logic [COUNT_W-1:0]      n_m2;
    logic signed [Q_W-1:0]   rd_x;
    logic signed [Q_W-1:0]   rd_y;
    logic                    scan_found;

    logic signed [Q_W:0]     den33;
    logic signed [Q_W:0]     dy33;
    logic signed [Q_W:0]     dx33;
    logic [Q_W:0]            dy_abs;
    logic                    den_pos;
    logic [DIVIDEND_W-1:0]   prod_full;

    logic                    div_done;
    logic [DIVIDEND_W-1:0]   div_quo;
    logic                    quo_big;
    logic [Q_W:0]            quo_sat;
    logic signed [Q_W+1:0]   sum34;
    logic [Q_W-1:0]          sum_sat;

    // Input unpacking.
    assign in_acc   = s_tvalid && s_tready;
    assign in_idx   = s_tdata[IDX_W-1:0];
    assign in_px    = s_tdata[IDX_W+Q_W-1:IDX_W];
    assign in_py    = s_tdata[IDX_W+2*Q_W-1:IDX_W+Q_W];
    assign in_qx    = s_tdata[IDX_W+3*Q_W-1:IDX_W+2*Q_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign wr_en    = in_acc && (s_tuser == OP_WRITE) && (32'(in_idx) < 32'(TABLE_DEPTH));

    // Points in use, limited to the table size.
    assign n_eff = (32'(count_reg) > 32'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : count_reg;
    assign n_m1  = n_reg - COUNT_W'(1);
    assign n_m2  = n_reg - COUNT_W'(2);

    assign rd_x = rd_data_reg[Q_W-1:0];
    assign rd_y = rd_data_reg[2*Q_W-1:Q_W];

    // The scan stops at the highest entry whose x does not exceed the query.
    assign scan_found = (rd_x <= qx_reg) || (scan_reg == '0);

    // Read address for the next cycle; the scan reads one entry ahead.
    always_comb
    begin
        unique case (state_reg)
            ST_LOAD0: rd_addr = AW'(n_m1);
            ST_LOADN: rd_addr = AW'(n_m2);
            ST_SCAN:  rd_addr = scan_found ? AW'(scan_reg + COUNT_W'(1))
                                           : AW'(scan_reg - COUNT_W'(1));
            default:  rd_addr = '0;
        endcase
    end

    // Breakpoint table, x in the low half and y in the high half.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[AW'(in_idx)] <= {in_py, in_px};
        end
        rd_data_reg <= tbl_mem[rd_addr];
    end

    // Segment differences, formed once the right breakpoint is read.
    always_comb
    begin
        den33   = {rd_x[Q_W-1], rd_x} - {x0_reg[Q_W-1], x0_reg};
        dy33    = {rd_y[Q_W-1], rd_y} - {y0_reg[Q_W-1], y0_reg};
        dx33    = {qx_reg[Q_W-1], qx_reg} - {x0_reg[Q_W-1], x0_reg};
        dy_abs  = dy33[Q_W] ? (~dy33 + (Q_W+1)'(1)) : dy33;
        den_pos = !den33[Q_W] && (den33 != '0);
    end

    assign prod_full = dx_reg * mag_reg;

    // Quotient limited to 2^32, then added to or subtracted from y0 by the sign of dy, and saturated.
    always_comb
    begin
        quo_big = (div_quo[DIVIDEND_W-1:Q_W+1] != '0) ||
                  (div_quo[Q_W] && (div_quo[Q_W-1:0] != '0));
        quo_sat = quo_big ? {1'b1, {Q_W{1'b0}}} : div_quo[Q_W:0];
        if (neg_reg)
        begin
            sum34 = {{2{y0_reg[Q_W-1]}}, y0_reg} - {1'b0, quo_sat};
        end
        else
        begin
            sum34 = {{2{y0_reg[Q_W-1]}}, y0_reg} + {1'b0, quo_sat};
        end
        if (sum34[Q_W+1:Q_W-1] == 3'b000 || sum34[Q_W+1:Q_W-1] == 3'b111)
        begin
            sum_sat = sum34[Q_W-1:0];
        end
        else if (sum34[Q_W+1])
        begin
            sum_sat = {1'b1, {(Q_W-1){1'b0}}};
        end
        else
        begin
            sum_sat = {1'b0, {(Q_W-1){1'b1}}};
        end
    end

    tint_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_LINEAR;
            count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INTERP_MODE: mode_reg  <= cfg_data[0];
                REG_POINT_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                default:         mode_reg  <= mode_reg;
            endcase
        end
    end

    // Query sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            scan_reg      <= '0;
            qx_reg        <= '0;
            x0_reg        <= '0;
            y0_reg        <= '0;
            dx_reg        <= '0;
            mag_reg       <= '0;
            den_reg       <= '0;
            neg_reg       <= 1'b0;
            prod_reg      <= '0;
            div_start_reg <= 1'b0;
            res_y_reg     <= '0;
            seg_reg       <= '0;
            status_reg    <= STATUS_OK;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= STATUS_OK;
        end
        else
        begin
            // The divider starts in the cycle after the product is taken.
            div_start_reg <= (state_reg == ST_MUL);

            // Output register: loaded as a query finishes, emptied once taken.
            if (state_reg == ST_FINISH && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {{(OUT_TDATA_W-Q_W-SEG_W){1'b0}},
                                 seg_reg[SEG_W-1:0], res_y_reg};
                m_tuser_reg  <= status_reg;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && s_tuser == OP_QUERY)
                    begin
                        qx_reg <= in_qx;
                        n_reg  <= n_eff;
                        if (n_eff < COUNT_W'(2))
                        begin
                            res_y_reg  <= '0;
                            seg_reg    <= '0;
                            status_reg <= STATUS_FEW;
                            state_reg  <= ST_FINISH;
                        end
                        else
                        begin
                            status_reg <= STATUS_OK;
                            state_reg  <= ST_LOAD0;
                        end
                    end
                end

                // First breakpoint: clamp below the table.
                ST_LOAD0:
                begin
                    x0_reg <= rd_x;
                    y0_reg <= rd_y;
                    if (qx_reg <= rd_x)
                    begin
                        res_y_reg <= rd_y;
                        seg_reg   <= '0;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_LOADN;
                    end
                end

                // Last breakpoint: clamp above the table.
                ST_LOADN:
                begin
                    if (qx_reg >= rd_x)
                    begin
                        res_y_reg <= rd_y;
                        seg_reg   <= n_m1;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        scan_reg  <= n_m2;
                        state_reg <= ST_SCAN;
                    end
                end

                // Walk down one entry per cycle to find the left breakpoint.
                ST_SCAN:
                begin
                    if (scan_found)
                    begin
                        seg_reg <= scan_reg;
                        x0_reg  <= rd_x;
                        y0_reg  <= rd_y;
                        if (mode_reg == MODE_STEP)
                        begin
                            res_y_reg <= rd_y;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_LOAD1;
                        end
                    end
                    else
                    begin
                        scan_reg <= scan_reg - COUNT_W'(1);
                    end
                end

                // Right breakpoint: a zero or negative x step gives y0.
                ST_LOAD1:
                begin
                    den_reg <= den33[Q_W-1:0];
                    dx_reg  <= dx33[Q_W-1:0];
                    mag_reg <= dy_abs[Q_W-1:0];
                    neg_reg <= dy33[Q_W];
                    if (!den_pos)
                    begin
                        res_y_reg <= y0_reg;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    prod_reg  <= prod_full;
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_SUM;
                    end
                end

                ST_SUM:
                begin
                    res_y_reg <= sum_sat;
                    state_reg <= ST_FINISH;
                end

                // Hand the result over once the output register is free.
                ST_FINISH:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

FILE: hdl/tint_checker.sv
`default_nettype none

// Port-level checks on the interpolator.
module tint_checker
    import tint_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic                   s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   m_tuser
);

    // A query beat occupies the block for at least the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == OP_QUERY) |=> !s_tready)
    else $error("input still ready straight after a query beat");

    // A breakpoint write never stalls the next beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == OP_WRITE) |=> s_tready)
    else $error("input stalled after a breakpoint write");

    // A stalled result beat holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result beat changed while stalled");

    // A result for too few points carries zero value and segment.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STATUS_FEW) |-> (m_tdata == '0))
    else $error("non-zero result with too few points");

endmodule

bind table_interpolator_top tint_checker u_tint_checker (.*);

`default_nettype wire
